@@ design/sbbt_pkg.sv @@
// ---------------------------------------------------------------------------
// sbbt_pkg: shared types and constants of the swept box trace
// Register indexes, widths and the divider request struct.
// ---------------------------------------------------------------------------
package sbbt_pkg;

    localparam int MAX_BRUSHES = 64;
    localparam int SLOT_W      = $clog2(MAX_BRUSHES);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int COORD_W     = 32;
    localparam int OFS_W       = 21;
    // plane and distance values: 32-bit coordinate minus 21-bit offset, then difference
    localparam int DIST_W      = 35;
    localparam int FRAC_W      = 17;
    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'd65536;

    localparam logic [2:0] REG_MIN_X = 3'd0;
    localparam logic [2:0] REG_MIN_Y = 3'd1;
    localparam logic [2:0] REG_MIN_Z = 3'd2;
    localparam logic [2:0] REG_MAX_X = 3'd3;
    localparam logic [2:0] REG_MAX_Y = 3'd4;
    localparam logic [2:0] REG_MAX_Z = 3'd5;
    localparam logic [2:0] REG_SOLID = 3'd6;
    localparam logic [2:0] REG_COUNT = 3'd7;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_TRACE = 1'b1;

    // divider request and answer
    typedef struct packed {
        logic                start;
        logic [DIST_W-1:0]   num;
        logic [DIST_W-1:0]   den;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [FRAC_W-1:0]   quot;
    } div_rsp_t;

endpackage

@@ design/swept_box_brush_trace.sv @@
// ---------------------------------------------------------------------------
// swept_box_brush_trace: swept player box against stored boxes
// Sequencer walking every box and plane through one shared divider.
// ---------------------------------------------------------------------------
// Usage: a load request (s_mode 0) writes one box and its surface word
// into slot s_slot; it gives no result. A trace request (s_mode 1)
// sweeps the configured player box from s_a_* to s_b_* against slots
// 0..brushes_in_use-1 (capped at slot 63; none while solid is off) and gives
// one result on the m_ channel. Each box is read from the store (S_READ,
// S_WAIT), up to six plane steps follow in S_PLANE and it closes in S_BOXEND;
// a plane that crosses goes through the shared divider, one quotient bit a cycle.
// Planes that do not cross skip the divider, and a box can be rejected early.
// s_ready is low from acceptance until the result has been taken; a stalled
// receiver holds the result in the output register.
// Configuration must be written through cfg_we / cfg_index / cfg_data only while idle; the block does not enforce this.
// Reset restores the player box, sets solid_enabled, clears brushes_in_use;
// the store has no reset and a never-loaded slot must not be traced.
// ---------------------------------------------------------------------------
module swept_box_brush_trace
    import sbbt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [OFS_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_mode,
    input  logic [5:0]           s_slot,
    input  logic signed [31:0]   s_a_x,
    input  logic signed [31:0]   s_a_y,
    input  logic signed [31:0]   s_a_z,
    input  logic signed [31:0]   s_b_x,
    input  logic signed [31:0]   s_b_y,
    input  logic signed [31:0]   s_b_z,
    input  logic [31:0]          s_surface_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [FRAC_W-1:0]    m_fraction,
    output logic [2:0]           m_normal_code,
    output logic                 m_start_solid,
    output logic                 m_all_solid,
    output logic [31:0]          m_surface_out,
    output logic                 m_hit_world,
    output logic                 m_walkable
);
    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_WAIT, S_PLANE, S_DIV, S_BOXEND, S_OUT
    } state_t;

    typedef logic signed [DIST_W-1:0] dist_t;

    state_t state_reg;

    // configuration
    logic signed [OFS_W-1:0] bmin_reg [3];
    logic signed [OFS_W-1:0] bmax_reg [3];
    logic                    solid_reg;
    logic [6:0]              count_reg;

    // trace context
    logic signed [COORD_W-1:0] st_reg [3];
    logic signed [COORD_W-1:0] en_reg [3];
    logic [CNT_W-1:0]          n_reg, idx_reg;
    logic [2:0]                side_reg;
    logic [FRAC_W-1:0]         enter_reg, leave_reg, best_reg;
    logic                      lead_reg, all_reg;
    logic [2:0]                nrm_reg, bnrm_reg;
    logic                      ss_reg, as_reg;
    logic [31:0]               bsurf_reg;
    logic                      dneg_reg;

    // box store
    logic [7*COORD_W-1:0] wr_data, rd_data;
    logic                 wr_en;
    logic [SLOT_W-1:0]    rd_addr;

    assign wr_en   = s_valid && s_ready && s_mode == MODE_LOAD &&
                     {1'b0, s_slot} < 7'(MAX_BRUSHES);
    assign wr_data = {s_surface_in, s_b_z, s_b_y, s_b_x, s_a_z, s_a_y, s_a_x};
    assign rd_addr = idx_reg[SLOT_W-1:0];

    sbbt_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s_slot[SLOT_W-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    div_req_t dreq;
    div_rsp_t drsp;

    sbbt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    // box held in registers while its planes are walked
    logic signed [COORD_W-1:0] bx_mn_reg [3];
    logic signed [COORD_W-1:0] bx_mx_reg [3];
    logic [31:0]               bx_surf_reg;

    // plane distances for the current side
    logic [1:0]  ax;
    logic        neg;
    dist_t       plane, d1, d2;
    always_comb begin
        neg = side_reg < 3'd3;
        ax  = neg ? side_reg[1:0] : 2'(side_reg - 3'd3);
        if (ax == 2'd3) ax = 2'd0;
        plane = neg ? DIST_W'(bx_mn_reg[ax]) - DIST_W'(bmax_reg[ax])
                    : DIST_W'(bx_mx_reg[ax]) - DIST_W'(bmin_reg[ax]);
        d1 = neg ? plane - DIST_W'(st_reg[ax]) : DIST_W'(st_reg[ax]) - plane;
        d2 = neg ? plane - DIST_W'(en_reg[ax]) : DIST_W'(en_reg[ax]) - plane;
    end

    logic out_cond;
    assign out_cond = (d1 < -dist_t'(1));

    // divider request on a crossing plane
    always_comb begin
        dreq.start = 1'b0;
        dreq.num   = '0;
        dreq.den   = '0;
        if (state_reg == S_PLANE) begin
            if (out_cond) begin
                dreq.start = (d2 > 0);
                dreq.num   = -d1;
                dreq.den   = d2 - d1;
            end else begin
                dreq.start = (d1 > d2) && (d1 > 0);
                dreq.num   = d1;
                dreq.den   = d1 - d2;
            end
        end
    end

    logic [2:0] side_next;
    assign side_next = side_reg + 3'd1;

    // sequencer and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            bmin_reg[0] <= -21'sd15360;
            bmin_reg[1] <= -21'sd15360;
            bmin_reg[2] <= 21'sd0;
            bmax_reg[0] <= 21'sd15360;
            bmax_reg[1] <= 21'sd15360;
            bmax_reg[2] <= 21'sd71680;
            solid_reg   <= 1'b1;
            count_reg   <= '0;
            m_valid     <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_MIN_X: bmin_reg[0] <= cfg_data;
                    REG_MIN_Y: bmin_reg[1] <= cfg_data;
                    REG_MIN_Z: bmin_reg[2] <= cfg_data;
                    REG_MAX_X: bmax_reg[0] <= cfg_data;
                    REG_MAX_Y: bmax_reg[1] <= cfg_data;
                    REG_MAX_Z: bmax_reg[2] <= cfg_data;
                    REG_SOLID: solid_reg   <= cfg_data[0];
                    REG_COUNT: count_reg   <= cfg_data[6:0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_mode == MODE_TRACE) begin
                        st_reg[0] <= s_a_x; st_reg[1] <= s_a_y; st_reg[2] <= s_a_z;
                        en_reg[0] <= s_b_x; en_reg[1] <= s_b_y; en_reg[2] <= s_b_z;
                        n_reg     <= !solid_reg ? '0 :
                                     (count_reg > 7'(MAX_BRUSHES) ? CNT_W'(MAX_BRUSHES)
                                                                  : CNT_W'(count_reg));
                        idx_reg   <= '0;
                        best_reg  <= FRAC_ONE;
                        bnrm_reg  <= '0;
                        bsurf_reg <= '0;
                        ss_reg    <= 1'b0;
                        as_reg    <= 1'b0;
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    if (idx_reg >= n_reg) begin
                        m_fraction    <= best_reg;
                        m_normal_code <= bnrm_reg;
                        m_start_solid <= ss_reg;
                        m_all_solid   <= as_reg;
                        m_surface_out <= bsurf_reg;
                        m_hit_world   <= best_reg < FRAC_ONE;
                        m_walkable    <= !ss_reg && bnrm_reg == 3'd6;
                        m_valid       <= 1'b1;
                        state_reg     <= S_OUT;
                    end else begin
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    bx_mn_reg[0] <= rd_data[31:0];
                    bx_mn_reg[1] <= rd_data[63:32];
                    bx_mn_reg[2] <= rd_data[95:64];
                    bx_mx_reg[0] <= rd_data[127:96];
                    bx_mx_reg[1] <= rd_data[159:128];
                    bx_mx_reg[2] <= rd_data[191:160];
                    bx_surf_reg  <= rd_data[223:192];
                    side_reg     <= '0;
                    enter_reg    <= '0;
                    leave_reg    <= best_reg;
                    lead_reg     <= 1'b0;
                    all_reg      <= 1'b1;
                    nrm_reg      <= '0;
                    state_reg    <= S_PLANE;
                end
                S_PLANE: begin
                    dneg_reg <= out_cond;
                    if (out_cond) begin
                        if (d2 <= 0) begin
                            side_reg  <= side_next;
                            state_reg <= (side_reg == 3'd5) ? S_BOXEND : S_PLANE;
                        end else begin
                            state_reg <= S_DIV;
                        end
                    end else if (d1 <= d2) begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_READ;
                    end else begin
                        if (d2 > 0) all_reg <= 1'b0;
                        if (d1 > 0) begin
                            state_reg <= S_DIV;
                        end else begin
                            // fraction zero: never above enter
                            if (!lead_reg) begin
                                nrm_reg  <= side_next;
                                lead_reg <= 1'b1;
                            end
                            side_reg  <= side_next;
                            state_reg <= (side_reg == 3'd5) ? S_BOXEND : S_PLANE;
                        end
                    end
                end
                S_DIV: begin
                    if (drsp.done) begin
                        side_reg  <= side_next;
                        state_reg <= (side_reg == 3'd5) ? S_BOXEND : S_PLANE;
                        if (dneg_reg) begin
                            if (drsp.quot <= enter_reg) begin
                                idx_reg   <= idx_reg + 1'b1;
                                state_reg <= S_READ;
                            end else begin
                                all_reg <= 1'b0;
                                if (drsp.quot < leave_reg) leave_reg <= drsp.quot;
                            end
                        end else if (drsp.quot > enter_reg) begin
                            enter_reg <= drsp.quot;
                            nrm_reg   <= side_next;
                            lead_reg  <= 1'b1;
                            if (leave_reg <= drsp.quot) begin
                                idx_reg   <= idx_reg + 1'b1;
                                state_reg <= S_READ;
                            end
                        end else if (!lead_reg) begin
                            nrm_reg  <= side_next;
                            lead_reg <= 1'b1;
                        end
                    end
                end
                S_BOXEND: begin
                    if (!lead_reg) begin
                        ss_reg <= 1'b1;
                        if (all_reg) begin
                            as_reg    <= 1'b1;
                            best_reg  <= '0;
                            bsurf_reg <= '0;
                        end
                    end else if (enter_reg < best_reg) begin
                        best_reg  <= enter_reg;
                        bnrm_reg  <= nrm_reg;
                        bsurf_reg <= bx_surf_reg;
                    end
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_READ;
                end
                S_OUT: begin
                    if (m_ready) begin
                        m_valid   <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

@@ design/sbbt_div.sv @@
// ---------------------------------------------------------------------------
// sbbt_div: restoring fraction divider
// floor(num*65536/den) saturated to 65536, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module sbbt_div
    import sbbt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);
    localparam int QB = FRAC_W + 1;
    localparam int CW = $clog2(QB + 1);

    logic [DIST_W:0]   rem_reg, rem_next;
    logic [DIST_W-1:0] den_reg;
    logic [QB-1:0]     q_reg, q_next;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg, done_reg;
    logic [DIST_W+1:0] trial;

    // quotient bits 16..0 from numerator shifted 16: integer bit then 16 fraction bits
    always_comb begin
        trial    = {rem_reg, 1'b0} - {2'b00, den_reg};
        rem_next = {rem_reg[DIST_W-1:0], 1'b0};
        q_next   = {q_reg[QB-2:0], 1'b0};
        if (!trial[DIST_W+1]) begin
            rem_next = trial[DIST_W:0];
            q_next[0] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(FRAC_W - 1);
                den_reg  <= req.den;
                // first step: integer quotient bit, set whenever num >= den
                if (req.num >= req.den) begin
                    rem_reg <= {1'b0, req.num - req.den};
                    q_reg   <= QB'(1);
                end else begin
                    rem_reg <= {1'b0, req.num};
                    q_reg   <= '0;
                end
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                q_reg   <= q_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // integer bit set means the quotient reached one: saturate
    always_comb begin
        rsp.done = done_reg;
        rsp.quot = (q_reg[QB-1:FRAC_W-1] != '0 && q_reg[QB-1]) ? FRAC_ONE :
                   ((q_reg[FRAC_W-1:0] > FRAC_ONE) ? FRAC_ONE : q_reg[FRAC_W-1:0]);
    end

endmodule

@@ design/sbbt_store.sv @@
// ---------------------------------------------------------------------------
// sbbt_store: box store
// One write port for loads, one registered read port for the sequencer.
// ---------------------------------------------------------------------------
module sbbt_store
    import sbbt_pkg::*;
(
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [SLOT_W-1:0]         wr_addr,
    input  logic [7*COORD_W-1:0]      wr_data,
    input  logic [SLOT_W-1:0]         rd_addr,
    output logic [7*COORD_W-1:0]      rd_data
);
    logic [7*COORD_W-1:0] mem [MAX_BRUSHES];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
